// ----- src/tcc_pkg.sv -----
// Shared types and constants for the text console cursor block.
package tcc_pkg;

  // Request kind
  typedef enum logic {
    KIND_CHAR  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

  // Result action
  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SCROLL = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  // Configuration register indexes
  typedef enum logic {
    REG_COLUMNS   = 1'b0,
    REG_TEXT_ROWS = 1'b1
  } reg_index_e;

  // Control characters
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Tab stops every eight columns
  localparam logic [8:0] TAB_STEP = 9'd8;
  localparam logic [8:0] TAB_MASK = ~9'd7;

  // Fixed hardware limits of the cursor registers
  localparam int unsigned COL_LIMIT = 256;
  localparam int unsigned ROW_LIMIT = 128;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] code;
  } char_req_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] cell_column;
    logic [6:0] cell_row;
    logic [7:0] glyph_code;
    logic       last;
  } res_item_t;

  // Outcome of one request: up to two results and the new cursor
  typedef struct packed {
    res_item_t  res0;
    res_item_t  res1;
    logic [1:0] count;
    logic [7:0] cursor_column;
    logic [6:0] cursor_row;
  } step_res_t;

endpackage

// ----- src/tcc_step.sv -----
// Combinational cursor update: decodes one request into results and a new cursor.
module tcc_step import tcc_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 128
) (
  input  char_req_t  req,
  input  logic [7:0] cursor_column,
  input  logic [6:0] cursor_row,
  input  logic [8:0] columns,
  input  logic [7:0] text_rows,
  output step_res_t  step
);

  localparam int unsigned COL_CAP_I = (MAX_COLUMNS > COL_LIMIT) ? COL_LIMIT : MAX_COLUMNS;
  localparam int unsigned ROW_CAP_I = (MAX_ROWS > ROW_LIMIT) ? ROW_LIMIT : MAX_ROWS;
  localparam logic [8:0]  COL_CAP   = 9'(COL_CAP_I);
  localparam logic [7:0]  ROW_CAP   = 8'(ROW_CAP_I);

  logic [8:0] ncol;
  logic [7:0] nrow;
  logic [8:0] cx0;
  logic [7:0] cy0;
  logic [8:0] cx;
  logic [7:0] cy;
  logic [8:0] cx_adv;
  logic       wr_en;
  logic [8:0] wr_col;
  logic [7:0] wr_glyph;
  logic       scroll;
  res_item_t  wr_item;
  res_item_t  sc_item;
  res_item_t  clr_item;

  // Effective screen size: zero acts as one, capped at the limit
  always_comb begin
    if (columns == 9'd0) ncol = 9'd1;
    else if (columns > COL_CAP) ncol = COL_CAP;
    else ncol = columns;
    if (text_rows == 8'd0) nrow = 8'd1;
    else if (text_rows > ROW_CAP) nrow = ROW_CAP;
    else nrow = text_rows;
  end

  // Clamp a cursor left outside a shrunken screen
  always_comb begin
    cx0 = ({1'b0, cursor_column} >= ncol) ? ncol - 9'd1 : {1'b0, cursor_column};
    cy0 = ({1'b0, cursor_row} >= nrow) ? nrow - 8'd1 : {1'b0, cursor_row};
  end

  // Character decode
  always_comb begin
    cx       = cx0;
    cy       = cy0;
    wr_en    = 1'b0;
    wr_col   = cx0;
    wr_glyph = req.code;
    case (req.code)
      CH_NEWLINE: begin
        cx = 9'd0;
        cy = cy0 + 8'd1;
      end
      CH_RETURN: begin
        cx = 9'd0;
      end
      CH_BACKSPACE: begin
        if (cx0 != 9'd0) begin
          cx       = cx0 - 9'd1;
          wr_en    = 1'b1;
          wr_col   = cx0 - 9'd1;
          wr_glyph = CH_SPACE;
        end
      end
      CH_TAB: begin
        cx = (cx0 + TAB_STEP) & TAB_MASK;
      end
      default: begin
        wr_en = 1'b1;
        cx    = cx0 + 9'd1;
      end
    endcase
  end

  // Wrap past the last column, scroll past the last row
  logic [7:0] cy_wrap;
  logic [8:0] cx_fin;
  logic [7:0] cy_fin;
  always_comb begin
    cx_adv  = cx;
    cy_wrap = cy;
    if (cx >= ncol) begin
      cx_adv  = 9'd0;
      cy_wrap = cy + 8'd1;
    end
    scroll = (cy_wrap >= nrow);
    cx_fin = cx_adv;
    cy_fin = scroll ? nrow - 8'd1 : cy_wrap;
  end

  // Result items
  always_comb begin
    wr_item             = '0;
    wr_item.action      = ACT_WRITE;
    wr_item.cell_column = wr_col[7:0];
    wr_item.cell_row    = cy0[6:0];
    wr_item.glyph_code  = wr_glyph;
    wr_item.last        = !scroll;
    sc_item             = '0;
    sc_item.action      = ACT_SCROLL;
    sc_item.last        = 1'b1;
    clr_item            = '0;
    clr_item.action     = ACT_CLEAR;
    clr_item.last       = 1'b1;
  end

  // Assemble the outcome
  always_comb begin
    step = '0;
    if (req.kind == KIND_CLEAR) begin
      step.res0  = clr_item;
      step.count = 2'd1;
    end else begin
      step.cursor_column = cx_fin[7:0];
      step.cursor_row    = cy_fin[6:0];
      if (wr_en) begin
        step.res0  = wr_item;
        step.res1  = sc_item;
        step.count = scroll ? 2'd2 : 2'd1;
      end else begin
        step.res0  = sc_item;
        step.count = scroll ? 2'd1 : 2'd0;
      end
    end
  end

endmodule

// ----- src/tcc_result_buf.sv -----
// Result register pair: holds the results of one request and hands them out in order.
module tcc_result_buf import tcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  step_res_t step,
  output logic      can_load,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res_item
);

  res_item_t  slot0;
  res_item_t  slot1;
  logic [1:0] left;
  logic       head;
  logic       take;

  assign res_valid = (left != 2'd0);
  assign res_item  = head ? slot1 : slot0;
  assign take      = res_valid && res_ready;
  assign can_load  = (left == 2'd0) || (take && left == 2'd1);

  // Count and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 2'd0;
      head <= 1'b0;
    end else if (load) begin
      left <= step.count;
      head <= 1'b0;
    end else if (take) begin
      left <= left - 2'd1;
      head <= 1'b1;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= step.res0;
      slot1 <= step.res1;
    end
  end

endmodule

// ----- src/text_console_cursor.sv -----
// Text console cursor: turns characters and clear requests into cell writes and commands.
//
// Channels: char_valid/char_ready/char_req takes one request (a character or a
// clear); res_valid/res_ready/res_item gives the cell writes, scrolls and clears
// it causes, zero to two per request, with last set on the final one.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes columns (index 0) and
// text_rows (index 1); writes are taken in every cycle and belong to idle time.
// A request waits in the input register until the result register pair can take it,
// and its first result is offered once it has been loaded there.
// Throughput: one request per cycle while each makes at most one result and the
// receiver takes each result; the result port moves one result per cycle while
// res_ready is high. The result register pair is the bound.
// Reset clears the cursor to home, sets 80 columns by 25 rows and empties both
// registers. When the receiver stalls, the current result holds, one further
// request waits in the input register and char_ready drops after that.
module text_console_cursor import tcc_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  char_req_t  char_req,
  output logic       res_valid,
  input  logic       res_ready,
  output res_item_t  res_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  reg_index_e cfg_index,
  input  logic [8:0] cfg_data
);

  logic       hold_valid;
  char_req_t  hold_req;
  logic [7:0] cursor_column;
  logic [6:0] cursor_row;
  logic [8:0] columns;
  logic [7:0] text_rows;
  step_res_t  step;
  logic       can_load;
  logic       advance;

  assign advance    = hold_valid && can_load;
  assign char_ready = !hold_valid || advance;
  assign cfg_ready  = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (char_ready) begin
      hold_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      hold_req <= char_req;
    end
  end

  // Cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= 8'd0;
      cursor_row    <= 7'd0;
    end else if (advance) begin
      cursor_column <= step.cursor_column;
      cursor_row    <= step.cursor_row;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      columns   <= 9'd80;
      text_rows <= 8'd25;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COLUMNS:   columns   <= cfg_data;
        REG_TEXT_ROWS: text_rows <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tcc_step #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_step (
    .req          (hold_req),
    .cursor_column(cursor_column),
    .cursor_row   (cursor_row),
    .columns      (columns),
    .text_rows    (text_rows),
    .step         (step)
  );

  tcc_result_buf u_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .step     (step),
    .can_load (can_load),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_item (res_item)
  );

`ifndef SYNTHESIS
  // A clear request homes the cursor
  a_clear_homes: assert property (@(posedge clk) disable iff (rst)
    advance && hold_req.kind == KIND_CLEAR |=> cursor_column == 8'd0 && cursor_row == 7'd0)
    else $error("cursor not home after clear");

  // Two results only as a cell write followed by a scroll
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    hold_valid && step.count == 2'd2 |->
      step.res0.action == ACT_WRITE && !step.res0.last &&
      step.res1.action == ACT_SCROLL && step.res1.last)
    else $error("bad result pair");

  // Commands carry zero cell fields
  a_cmd_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.action != ACT_WRITE |->
      res_item.cell_column == 8'd0 && res_item.cell_row == 7'd0 &&
      res_item.glyph_code == 8'd0)
    else $error("command with nonzero cell fields");

  // A clear is always the only result of its request
  a_clear_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.action == ACT_CLEAR |-> res_item.last)
    else $error("clear not marked last");
`endif

endmodule
